// ===== hw/rtl/priority_bitmap_task_scheduler_macros.svh =====
// Assertion macros used by the scheduler queue sequencer (pbts_ctrl)
`ifndef PRIORITY_BITMAP_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_BITMAP_TASK_SCHEDULER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define PBTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset
`define PBTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ===== hw/rtl/pbts_pkg.sv =====
// Types, constants and helper functions of the task scheduler
package pbts_pkg;

    localparam int NUM_TASKS  = 32;
    localparam int NUM_LEVELS = 32;
    localparam int TW = $clog2(NUM_TASKS);
    localparam int LW = $clog2(NUM_LEVELS);

    // item function codes
    localparam logic [1:0] FN_START  = 2'd0;
    localparam logic [1:0] FN_SCHED  = 2'd1;
    localparam logic [1:0] FN_SWITCH = 2'd2;

    // outgoing reasons
    localparam logic [1:0] RS_PREEMPT = 2'd0;
    localparam logic [1:0] RS_YIELD   = 2'd1;
    localparam logic [1:0] RS_BLOCK   = 2'd2;
    localparam logic [1:0] RS_DEAD    = 2'd3;

    // configuration register indexes
    localparam logic CFG_MAX_PRI = 1'b0;
    localparam logic CFG_TIMER   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_UL_A, ST_UL_B, ST_UL_C, ST_LK_A, ST_LK_B, ST_LK_C,
        ST_LVW, ST_CHOOSE, ST_PK_A, ST_PK_B, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_START, PH_OLD_UL, PH_OLD_LK, PH_PICK_UL
    } t_phase;

    typedef struct packed {
        logic [1:0]        func;
        logic [4:0]        task_id;
        logic signed [6:0] priority_req;
        logic              start_as_current;
        logic [1:0]        outgoing_reason;
    } t_item;

    typedef struct packed {
        logic [4:0] running_task;
        logic       running_valid;
        logic       context_switch;
        logic [4:0] outgoing_task;
    } t_res;

    typedef struct packed {
        logic [4:0] max_priority;
        logic [4:0] timer_task;
    } t_cfg;

    // highest set bit of the level bitmap
    function automatic logic [LW-1:0] highest_level(input logic [NUM_LEVELS-1:0] bm);
        logic [LW-1:0] r;
        r = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (bm[i]) r = LW'(i);
        end
        return r;
    endfunction

    // clamp a requested priority; the timer task always takes the top level
    function automatic logic [4:0] clamp_level(input logic [4:0] id,
                                               input logic signed [6:0] pri,
                                               input t_cfg cfg);
        logic [4:0] top;
        logic [4:0] r;
        top = (cfg.max_priority == 5'd0) ? 5'd0 : cfg.max_priority - 5'd1;
        if (id == cfg.timer_task) begin
            r = cfg.max_priority;
        end else if (pri < 7'sd0) begin
            r = 5'd0;
        end else if (pri > $signed({2'b00, top})) begin
            r = top;
        end else begin
            r = pri[4:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/pbts_in_if.sv =====
// Input channel of the scheduler: valid, ready and one scheduling item
interface pbts_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [4:0]        task_id;
    logic signed [6:0] priority_req;
    logic              start_as_current;
    logic [1:0]        outgoing_reason;

    modport source (output valid, func, task_id, priority_req, start_as_current,
                    outgoing_reason, input ready);
    modport sink   (input valid, func, task_id, priority_req, start_as_current,
                    outgoing_reason, output ready);
endinterface

// ===== hw/rtl/pbts_out_if.sv =====
// Output channel of the scheduler: valid, ready and one result item
interface pbts_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] running_task;
    logic       running_valid;
    logic       context_switch;
    logic [4:0] outgoing_task;

    modport source (output valid, running_task, running_valid, context_switch,
                    outgoing_task, input ready);
    modport sink   (input valid, running_task, running_valid, context_switch,
                    outgoing_task, output ready);
endinterface

// ===== hw/rtl/pbts_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module pbts_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/pbts_ctrl.sv =====
// Queue sequencer: unlink, relink and dequeue over the queue memories
`include "priority_bitmap_task_scheduler_macros.svh"
module pbts_ctrl import pbts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_item_valid,
    output logic  o_item_ready,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    input  logic  i_slot_free,
    output logic  o_res_valid,
    output t_res  o_res
);
    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    t_item  r_item;
    logic [TW-1:0] r_t, r_p, r_n, r_old, r_cur, r_park;
    logic [LW-1:0] r_lv;
    logic r_at_head, r_found, r_old_v, r_cur_v, r_park_v;
    logic [NUM_TASKS-1:0]  r_queued;
    logic [NUM_LEVELS-1:0] r_ready;

    // memory ports
    logic          lvl_we, nxt_we, prv_we, hd_we, tl_we;
    logic [TW-1:0] lvl_waddr, nxt_waddr, prv_waddr;
    logic [LW-1:0] hd_waddr, tl_waddr, hd_raddr;
    logic [LW-1:0] lvl_wdata, lvl_rdata;
    logic [TW-1:0] nxt_wdata, nxt_rdata, prv_wdata, prv_rdata;
    logic [TW-1:0] hd_wdata, hd_rdata, tl_wdata, tl_rdata;

    pbts_ram #(.WIDTH(LW), .DEPTH(NUM_TASKS)) u_level (
        .i_clk, .i_we(lvl_we), .i_waddr(lvl_waddr), .i_wdata(lvl_wdata),
        .i_raddr(r_t), .o_rdata(lvl_rdata));
    pbts_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_next (
        .i_clk, .i_we(nxt_we), .i_waddr(nxt_waddr), .i_wdata(nxt_wdata),
        .i_raddr(r_t), .o_rdata(nxt_rdata));
    pbts_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_prev (
        .i_clk, .i_we(prv_we), .i_waddr(prv_waddr), .i_wdata(prv_wdata),
        .i_raddr(r_t), .o_rdata(prv_rdata));
    pbts_ram #(.WIDTH(TW), .DEPTH(NUM_LEVELS)) u_head (
        .i_clk, .i_we(hd_we), .i_waddr(hd_waddr), .i_wdata(hd_wdata),
        .i_raddr(hd_raddr), .o_rdata(hd_rdata));
    pbts_ram #(.WIDTH(TW), .DEPTH(NUM_LEVELS)) u_tail (
        .i_clk, .i_we(tl_we), .i_waddr(tl_waddr), .i_wdata(tl_wdata),
        .i_raddr(hd_raddr), .o_rdata(tl_rdata));

    logic accept, ul_head, ul_tail, lk_empty, same_task;
    assign accept    = i_item_valid && o_item_ready;
    assign ul_head   = (hd_rdata == r_t);
    assign ul_tail   = (tl_rdata == r_t);
    assign lk_empty  = !r_ready[lvl_rdata];
    assign same_task = r_old_v && (r_old == r_t) && (r_item.outgoing_reason != RS_DEAD);

    // next state and phase
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_item.func == FN_START) begin
                        n_state = ST_UL_A;
                        n_phase = PH_START;
                    end else if (r_cur_v) begin
                        n_state = ST_UL_A;
                        n_phase = PH_OLD_UL;
                    end else begin
                        n_state = ST_CHOOSE;
                    end
                end
            end
            ST_UL_A: n_state = r_queued[r_t] ? ST_UL_B : ST_UL_C;
            ST_UL_B: n_state = ST_UL_C;
            ST_UL_C: begin
                // unlink finished: continue by phase
                case (r_phase)
                    PH_START: n_state = ST_LVW;
                    PH_OLD_UL: begin
                        if (r_item.outgoing_reason == RS_PREEMPT ||
                            r_item.outgoing_reason == RS_YIELD) begin
                            n_state = ST_LK_A;
                            n_phase = PH_OLD_LK;
                        end else begin
                            n_state = ST_CHOOSE;
                        end
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_LK_A: n_state = ST_LK_B;
            ST_LK_B: begin
                if (lk_empty) begin
                    n_state = (r_phase == PH_START) ? ST_DONE : ST_CHOOSE;
                end else begin
                    n_state = ST_LK_C;
                end
            end
            ST_LK_C: n_state = (r_phase == PH_START) ? ST_DONE : ST_CHOOSE;
            ST_LVW:  n_state = r_item.start_as_current ? ST_DONE : ST_LK_A;
            ST_CHOOSE: begin
                if (r_item.func == FN_SWITCH) begin
                    n_state = ST_UL_A;
                    n_phase = PH_PICK_UL;
                end else if (|r_ready) begin
                    n_state = ST_PK_A;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_PK_A: n_state = ST_PK_B;
            ST_PK_B: begin
                n_state = ST_UL_A;
                n_phase = PH_PICK_UL;
            end
            ST_DONE: n_state = i_slot_free ? ST_IDLE : ST_DONE;
            default: n_state = ST_IDLE;
        endcase
    end

    // memory controls and result
    always_comb begin
        lvl_we = 1'b0; nxt_we = 1'b0; prv_we = 1'b0; hd_we = 1'b0; tl_we = 1'b0;
        lvl_waddr = r_t; lvl_wdata = clamp_level(r_t, r_item.priority_req, i_cfg);
        nxt_waddr = r_p; nxt_wdata = r_n;
        prv_waddr = r_n; prv_wdata = r_p;
        hd_waddr  = r_lv; hd_wdata = r_n;
        tl_waddr  = r_lv; tl_wdata = r_p;
        hd_raddr  = (r_state == ST_PK_A) ? r_lv : lvl_rdata;
        case (r_state)
            ST_UL_C: begin
                if (r_queued[r_t]) begin
                    if (ul_head && ul_tail) begin
                        hd_we = 1'b0;
                    end else if (ul_head) begin
                        hd_we = 1'b1;
                    end else if (ul_tail) begin
                        tl_we = 1'b1;
                    end else begin
                        nxt_we = 1'b1;
                        prv_we = 1'b1;
                    end
                end
            end
            ST_LK_B: begin
                // empty level: task becomes head and tail
                hd_waddr = lvl_rdata; hd_wdata = r_t;
                tl_waddr = lvl_rdata; tl_wdata = r_t;
                hd_we = lk_empty;
                tl_we = lk_empty;
            end
            ST_LK_C: begin
                if (r_at_head) begin
                    prv_we = 1'b1; prv_waddr = hd_rdata; prv_wdata = r_t;
                    nxt_we = 1'b1; nxt_waddr = r_t;      nxt_wdata = hd_rdata;
                    hd_we  = 1'b1; hd_wdata = r_t;
                end else begin
                    nxt_we = 1'b1; nxt_waddr = tl_rdata; nxt_wdata = r_t;
                    prv_we = 1'b1; prv_waddr = r_t;      prv_wdata = tl_rdata;
                    tl_we  = 1'b1; tl_wdata = r_t;
                end
            end
            ST_LVW: lvl_we = 1'b1;
            default: lvl_we = 1'b0;
        endcase

        o_res = '0;
        if (r_item.func == FN_START) begin
            o_res.running_valid = r_cur_v;
            o_res.running_task  = r_cur_v ? r_cur : '0;
        end else if (r_found) begin
            o_res.running_valid  = 1'b1;
            o_res.running_task   = r_t;
            o_res.context_switch = !same_task;
            if (!same_task) begin
                o_res.outgoing_task = r_old_v ? r_old : (r_park_v ? r_park : '0);
            end
        end
    end

    assign o_item_ready = (r_state == ST_IDLE);
    assign o_res_valid  = (r_state == ST_DONE) && i_slot_free;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_START;
            r_cur_v  <= 1'b0;
            r_park_v <= 1'b0;
            r_queued <= '0;
            r_ready  <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            case (r_state)
                ST_UL_C: begin
                    if (r_queued[r_t]) begin
                        r_queued[r_t] <= 1'b0;
                        if (ul_head && ul_tail) r_ready[r_lv] <= 1'b0;
                    end
                end
                ST_LK_B: begin
                    if (lk_empty) begin
                        r_ready[lvl_rdata] <= 1'b1;
                        r_queued[r_t]      <= 1'b1;
                    end
                end
                ST_LK_C: r_queued[r_t] <= 1'b1;
                ST_LVW: begin
                    if (r_item.start_as_current) r_cur_v <= 1'b1;
                end
                ST_DONE: begin
                    if (i_slot_free && r_item.func != FN_START) begin
                        if (r_found) begin
                            r_cur_v <= 1'b1;
                            if (!same_task) r_park_v <= 1'b0;
                        end else begin
                            r_cur_v <= 1'b0;
                            if (r_old_v) r_park_v <= 1'b1;
                        end
                    end
                end
                default: r_cur_v <= r_cur_v;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_item    <= i_item;
                    r_t       <= (i_item.func == FN_START) ? i_item.task_id : r_cur;
                    r_old     <= r_cur;
                    r_old_v   <= r_cur_v;
                    r_found   <= 1'b0;
                    r_at_head <= (i_item.func != FN_START) &&
                                 (i_item.outgoing_reason == RS_PREEMPT);
                end
            end
            ST_UL_B: begin
                r_lv <= lvl_rdata;
                r_p  <= prv_rdata;
                r_n  <= nxt_rdata;
            end
            ST_LK_B: r_lv <= lvl_rdata;
            ST_LVW: begin
                if (r_item.start_as_current) r_cur <= r_t;
            end
            ST_CHOOSE: begin
                if (r_item.func == FN_SWITCH) begin
                    r_t     <= r_item.task_id;
                    r_found <= 1'b1;
                end else begin
                    r_lv <= highest_level(r_ready);
                end
            end
            ST_PK_B: begin
                r_t     <= hd_rdata;
                r_found <= 1'b1;
            end
            ST_DONE: begin
                if (i_slot_free && r_item.func != FN_START) begin
                    if (r_found) begin
                        r_cur <= r_t;
                        if (!same_task) r_park <= '0;
                    end else begin
                        r_cur <= '0;
                        if (r_old_v) r_park <= r_old;
                    end
                end
            end
            default: r_lv <= r_lv;
        endcase
    end

    `PBTS_ASSERT_NOW(a_link_unqueued, r_state == ST_LK_A, !r_queued[r_t])
    `PBTS_ASSERT_NOW(a_idle_no_switch, o_res_valid && !o_res.running_valid, !o_res.context_switch)
    `PBTS_ASSERT_NEXT(a_found_runs, o_res_valid && r_found && r_item.func != FN_START, r_cur_v)
    `PBTS_ASSERT_NOW(a_pick_level_busy, r_state == ST_PK_A, r_ready[r_lv])
endmodule

// ===== hw/rtl/priority_bitmap_task_scheduler.sv =====
// Top level of the bitmap priority task scheduler
//
//   channel  direction  carries
//   i_in     sink       func, task_id, priority_req, start_as_current, outgoing_reason
//   o_out    source     running_task, running_valid, context_switch, outgoing_task
//   i_cfg_*  write      max_priority (index 0), timer_task (index 1)
//
// One item at a time: the next item is taken only after the current one has run its
// sequence of unlink (with a pointer read when the task is queued), relink (with a list
// update into a busy level), level pick and the result state.
// Reset is synchronous, active low; queue memories need no clearing pass.
// A result waits in the output register while the next item is taken in; the result
// cycle stalls while that register is full and not being taken.
module priority_bitmap_task_scheduler import pbts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pbts_in_if.sink     i_in,
    pbts_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [4:0]  i_cfg_data
);
    t_cfg  r_cfg;
    t_item item;
    t_res  res, r_res;
    logic  res_valid, slot_free, r_out_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_priority <= 5'd31;
            r_cfg.timer_task   <= 5'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MAX_PRI) r_cfg.max_priority <= i_cfg_data;
            if (i_cfg_idx == CFG_TIMER)   r_cfg.timer_task   <= i_cfg_data;
        end
    end

    assign item.func             = i_in.func;
    assign item.task_id          = i_in.task_id;
    assign item.priority_req     = i_in.priority_req;
    assign item.start_as_current = i_in.start_as_current;
    assign item.outgoing_reason  = i_in.outgoing_reason;

    pbts_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_item_valid(i_in.valid), .o_item_ready(i_in.ready), .i_item(item),
        .i_cfg(r_cfg), .i_slot_free(slot_free),
        .o_res_valid(res_valid), .o_res(res));

    // output register
    assign slot_free = !r_out_valid || o_out.ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= res_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (slot_free && res_valid) r_res <= res;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.running_task   = r_res.running_task;
    assign o_out.running_valid  = r_res.running_valid;
    assign o_out.context_switch = r_res.context_switch;
    assign o_out.outgoing_task  = r_res.outgoing_task;
endmodule
